// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the graph store RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define AMGS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("amgs assertion failed");

// same-cycle implication checked outside reset
`define AMGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amgs implication failed");

`endif

// File: design/amgs_pkg.sv
// ----------------------------------------------------------------------------
// amgs_pkg
// Types, constants and helpers for the adjacency matrix graph store
// ----------------------------------------------------------------------------
package amgs_pkg;

  localparam int MaxVertices = 64;
  localparam int RowW        = 64;
  localparam int NumRows     = (MaxVertices < RowW) ? MaxVertices : RowW;
  localparam int RowIdxW     = $clog2(NumRows);
  localparam int VtxW        = 6;
  localparam int CountW      = 7;
  localparam int DegW        = 7;
  localparam int EdgeW       = 13;
  localparam int CfgDataW    = 7;
  localparam int CfgIdxW     = 2;

  localparam logic [EdgeW-1:0]  EdgeTotalMax    = EdgeW'(4096);
  localparam logic [CountW-1:0] VertexCountRst  = CountW'(64);

  typedef logic [VtxW-1:0]    vtx_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [RowIdxW-1:0] row_idx_t;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpRemove = 2'd1,
    OpQuery  = 2'd2,
    OpDegree = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgVertexCount = 2'd0,
    CfgDirected    = 2'd1,
    CfgSimple      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic     en;
    logic     set;
    logic     mirror;
    row_idx_t row;
    vtx_t     col;
  } wr_cmd_t;

  // population count as a fixed adder tree
  function automatic logic [DegW-1:0] popcount_row(input row_t x);
    logic [2:0] l1 [16];
    logic [3:0] l2 [8];
    logic [4:0] l3 [4];
    logic [5:0] l4 [2];
    for (int i = 0; i < 16; i++) begin
      l1[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = 4'(l1[2*i]) + 4'(l1[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = 5'(l2[2*i]) + 5'(l2[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = 6'(l3[2*i]) + 6'(l3[2*i+1]);
    end
    return DegW'(l4[0]) + DegW'(l4[1]);
  endfunction

endpackage

// File: design/amgs_matrix.sv
// ----------------------------------------------------------------------------
// amgs_matrix
// Register-held adjacency bit matrix with edge and mirror bit write
// ----------------------------------------------------------------------------
module amgs_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  amgs_pkg::wr_cmd_t  wr_i,
  input  amgs_pkg::row_idx_t rd_u_i,
  input  amgs_pkg::vtx_t     rd_v_i,
  output logic               present_o,
  output amgs_pkg::row_t     row_v_o
);

  amgs_pkg::row_t rows_q [amgs_pkg::NumRows];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < amgs_pkg::NumRows; i++) begin
        rows_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      rows_q[wr_i.row][wr_i.col] <= wr_i.set;
      if (wr_i.mirror) begin
        rows_q[wr_i.col[amgs_pkg::RowIdxW-1:0]][wr_i.row] <= wr_i.set;
      end
    end
  end

  assign present_o = rows_q[rd_u_i][rd_v_i];
  assign row_v_o   = rows_q[rd_v_i[amgs_pkg::RowIdxW-1:0]];

endmodule

// File: design/adjacency_matrix_graph_store.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Bit-matrix graph store: add, remove, query edge and vertex degree
//
//   channel  direction  handshake              payload
//   in       to block   in_valid_i/in_stall_o  opcode, row_vertex, column_vertex
//   out      from block out_valid_o/out_stall_i ok, degree, edge_count
//   cfg      to block   cfg_we_i               cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the result is not stalled
// the matrix read-modify-write and the row popcount sit between the input
// register and the result register
// reset clears the whole matrix and the edge total at once
// a stalled result holds the input register, which then stalls the input
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adjacency_matrix_graph_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [amgs_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [amgs_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic [amgs_pkg::VtxW-1:0]           row_vertex_i,
  input  logic [amgs_pkg::VtxW-1:0]           column_vertex_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                ok_o,
  output logic [amgs_pkg::DegW-1:0]           degree_o,
  output logic [amgs_pkg::EdgeW-1:0]          edge_count_o
);

  logic [amgs_pkg::CountW-1:0] vcount_q;
  logic                        directed_q;
  logic                        simple_q;

  logic                        in_vld_q;
  amgs_pkg::op_e               op_q;
  amgs_pkg::vtx_t              u_q;
  amgs_pkg::vtx_t              v_q;

  logic                        out_vld_q;
  logic                        out_ok_q;
  logic [amgs_pkg::DegW-1:0]   out_deg_q;
  logic [amgs_pkg::EdgeW-1:0]  out_edges_q;

  logic [amgs_pkg::EdgeW-1:0]  edge_total_q, edge_total_d;

  logic                        advance;
  logic                        in_xfer;
  logic [amgs_pkg::CountW-1:0] n_eff;
  logic                        vld_u, vld_v;
  logic                        present;
  amgs_pkg::row_t              row_v;
  amgs_pkg::row_t              deg_row;
  logic                        ok_d;
  logic [amgs_pkg::DegW-1:0]   deg_d;
  amgs_pkg::wr_cmd_t           wr_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= amgs_pkg::VertexCountRst;
      directed_q <= 1'b0;
      simple_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        amgs_pkg::CfgVertexCount: vcount_q   <= cfg_data_i;
        amgs_pkg::CfgDirected:    directed_q <= cfg_data_i[0];
        amgs_pkg::CfgSimple:      simple_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= amgs_pkg::op_e'(opcode_i);
      u_q  <= row_vertex_i;
      v_q  <= column_vertex_i;
    end
  end

  assign n_eff = (vcount_q > amgs_pkg::CountW'(amgs_pkg::NumRows)) ?
                 amgs_pkg::CountW'(amgs_pkg::NumRows) : vcount_q;
  assign vld_u = {1'b0, u_q} < n_eff;
  assign vld_v = {1'b0, v_q} < n_eff;

  amgs_matrix u_matrix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr_cmd),
    .rd_u_i    (u_q[amgs_pkg::RowIdxW-1:0]),
    .rd_v_i    (v_q),
    .present_o (present),
    .row_v_o   (row_v)
  );

  // columns in use, diagonal dropped in simple mode
  always_comb begin
    for (int c = 0; c < amgs_pkg::RowW; c++) begin
      deg_row[c] = row_v[c] && (amgs_pkg::CountW'(c) < n_eff) &&
                   !(simple_q && (amgs_pkg::VtxW'(c) == v_q));
    end
  end

  always_comb begin
    ok_d         = 1'b0;
    deg_d        = '0;
    edge_total_d = edge_total_q;
    wr_cmd.en     = 1'b0;
    wr_cmd.set    = 1'b0;
    wr_cmd.mirror = !directed_q && (u_q != v_q);
    wr_cmd.row    = u_q[amgs_pkg::RowIdxW-1:0];
    wr_cmd.col    = v_q;
    unique case (op_q)
      amgs_pkg::OpAdd: begin
        ok_d       = vld_u && vld_v && !(simple_q && (u_q == v_q)) && !present;
        wr_cmd.set = 1'b1;
        if (ok_d && (edge_total_q < amgs_pkg::EdgeTotalMax)) begin
          edge_total_d = edge_total_q + amgs_pkg::EdgeW'(1);
        end
      end
      amgs_pkg::OpRemove: begin
        ok_d = vld_u && vld_v && present;
        if (ok_d && (edge_total_q != '0)) begin
          edge_total_d = edge_total_q - amgs_pkg::EdgeW'(1);
        end
      end
      amgs_pkg::OpQuery: begin
        ok_d = vld_u && vld_v && present;
      end
      amgs_pkg::OpDegree: begin
        ok_d = vld_v;
        if (vld_v) begin
          deg_d = amgs_pkg::popcount_row(deg_row);
        end
      end
      default: ;
    endcase
    wr_cmd.en = advance && ok_d &&
                ((op_q == amgs_pkg::OpAdd) || (op_q == amgs_pkg::OpRemove));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
    end else if (advance) begin
      edge_total_q <= edge_total_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ok_q    <= ok_d;
      out_deg_q   <= deg_d;
      out_edges_q <= edge_total_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign ok_o         = out_ok_q;
  assign degree_o     = out_deg_q;
  assign edge_count_o = out_edges_q;

  `AMGS_ASSERT(a_edge_bound, clk_i, rst_ni, edge_total_q <= amgs_pkg::EdgeTotalMax)
  `AMGS_ASSERT_IMP(a_deg_ok, clk_i, rst_ni, out_vld_q && (out_deg_q != '0), out_ok_q)
  `AMGS_ASSERT_IMP(a_total_shown, clk_i, rst_ni, out_vld_q, out_edges_q == edge_total_q)
  `AMGS_ASSERT_IMP(a_total_move, clk_i, rst_ni,
                   edge_total_q != $past(edge_total_q), out_vld_q && out_ok_q)

endmodule

// File: tb/sv/adjacency_matrix_graph_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_tb
// Self-checking bench for the adjacency matrix graph store
//
// A tracker class keeps its own copy of the bit matrix, the edge total and
// the three registers, works out ok, degree and edge count for every input
// transfer and compares each output transfer against the oldest prediction.
// A short directed run covers the opcodes, the vertex extremes, self-loops,
// rejected vertices, masking under a shrunk count and the edge total held at
// zero after a mode switch. Random phases follow under a range of register
// settings, with random idling on both channels, one long receiver hold-off
// and pauses of the sender until the block has drained.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_tb;
  import amgs_pkg::*;

  typedef struct packed {
    logic             ok;
    logic [DegW-1:0]  degree;
    logic [EdgeW-1:0] edge_count;
  } outcome_t;

  class adjacency_tracker;
    logic [RowW-1:0]   rows [MaxVertices];
    logic [EdgeW-1:0]  edge_total;
    logic [CountW-1:0] vertex_limit;
    logic              directed;
    logic              simple;
    outcome_t          awaited [$];
    int                failures;

    function new();
      foreach (rows[i]) rows[i] = '0;
      edge_total   = '0;
      vertex_limit = VertexCountRst;
      directed     = 1'b0;
      simple       = 1'b1;
      failures     = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgVertexCount: vertex_limit = value[CountW-1:0];
        CfgDirected:    directed     = value[0];
        CfgSimple:      simple       = value[0];
        default: ;
      endcase
    endfunction

    function int active_count();
      int n;
      n = vertex_limit;
      if (n > MaxVertices) n = MaxVertices;
      if (n > 64) n = 64;
      return n;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function void note_transfer(op_e op, vtx_t u, vtx_t v);
      int              n;
      logic [RowW-1:0] mask;
      logic [RowW-1:0] row;
      logic            present;
      outcome_t        res;
      n   = active_count();
      res = '0;
      if (op == OpDegree) begin
        if (v < n) begin
          mask = (n >= 64) ? {RowW{1'b1}} : ((RowW'(1) << n) - RowW'(1));
          row  = rows[v] & mask;
          if (simple) row[v] = 1'b0;
          res.degree = DegW'($countones(row));
          res.ok     = 1'b1;
        end
      end else if (u < n && v < n) begin
        present = rows[u][v];
        case (op)
          OpAdd: begin
            if (!(simple && u == v) && !present) begin
              rows[u][v] = 1'b1;
              if (!directed && u != v) rows[v][u] = 1'b1;
              if (edge_total < EdgeTotalMax) edge_total = edge_total + 1'b1;
              res.ok = 1'b1;
            end
          end
          OpRemove: begin
            if (present) begin
              rows[u][v] = 1'b0;
              if (!directed && u != v) rows[v][u] = 1'b0;
              if (edge_total > 0) edge_total = edge_total - 1'b1;
              res.ok = 1'b1;
            end
          end
          default: res.ok = present;
        endcase
      end
      res.edge_count = edge_total;
      awaited.push_back(res);
    endfunction

    function void check_result(logic ok, logic [DegW-1:0] deg, logic [EdgeW-1:0] ec);
      outcome_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: ok %0d degree %0d edge_count %0d", ok, deg, ec);
        failures++;
      end else begin
        want = awaited.pop_front();
        if (ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok);
          failures++;
        end
        if (deg !== want.degree) begin
          $error("degree: expected %0d, got %0d", want.degree, deg);
          failures++;
        end
        if (ec !== want.edge_count) begin
          $error("edge_count: expected %0d, got %0d", want.edge_count, ec);
          failures++;
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          opcode_i;
  logic [VtxW-1:0]     row_vertex_i;
  logic [VtxW-1:0]     column_vertex_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                ok_o;
  logic [DegW-1:0]     degree_o;
  logic [EdgeW-1:0]    edge_count_o;

  adjacency_tracker graph = new();
  bit               quiet_phase   = 1'b0;
  bit               hold_request  = 1'b0;

  adjacency_matrix_graph_store dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .row_vertex_i    (row_vertex_i),
    .column_vertex_i (column_vertex_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .degree_o        (degree_o),
    .edge_count_o    (edge_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic vtx_t pick_vertex(int n);
    if (n > 0 && $urandom_range(0, 9) < 8) return vtx_t'($urandom_range(0, n - 1));
    return vtx_t'($urandom_range(0, 63));
  endfunction

  // receiver: random stall pattern, long hold-off on request
  initial begin
    int idle_len;
    int run_len;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        idle_len     = 120;
        hold_request = 1'b0;
      end else begin
        idle_len = pick_gap();
      end
      if (idle_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (idle_len) @(posedge clk_i);
      end
      run_len = $urandom_range(1, 16);
      out_stall_i <= 1'b0;
      repeat (run_len) @(posedge clk_i);
    end
  end

  // output transfers sampled mid-cycle, once everything has settled
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      graph.check_result(ok_o, degree_o, edge_count_o);
    end
  end

  task automatic send(op_e op, vtx_t u, vtx_t v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    row_vertex_i    <= u;
    column_vertex_i <= v;
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    graph.note_transfer(op, u, v);
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (graph.outstanding() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    graph.write_register(idx, CfgDataW'(value));
    @(posedge clk_i);
  endtask

  task automatic configure(int vertices, int dir, int simple_loops);
    settle();
    write_reg(CfgVertexCount, vertices);
    write_reg(CfgDirected, dir);
    write_reg(CfgSimple, simple_loops);
  endtask

  task automatic random_phase(int items);
    int   done;
    int   n;
    int   pick;
    vtx_t u;
    vtx_t v;
    done = 0;
    n    = graph.active_count();
    while (done < items) begin
      pick = $urandom_range(0, 99);
      u    = pick_vertex(n);
      v    = pick_vertex(n);
      if (pick < 55) begin
        send(op_e'($urandom_range(0, 3)), u, v);
        done += 1;
      end else if (pick < 90) begin
        // edge life: add, look at it, maybe take it away again
        send(OpAdd, u, v);
        send(OpQuery, u, v);
        send(OpDegree, vtx_t'($urandom_range(0, 63)), u);
        send(OpDegree, vtx_t'($urandom_range(0, 63)), v);
        if ($urandom_range(0, 1)) begin
          send(OpRemove, u, v);
          send(OpQuery, v, u);
        end
        done += 6;
      end else if (pick < 97) begin
        // broken sequences: remove first, add twice
        send(OpRemove, u, v);
        send(OpAdd, u, v);
        send(OpAdd, u, v);
        done += 3;
      end else if (n > 0) begin
        // star around one hub, then its degree
        for (int c = 0; c < n; c++) send(OpAdd, u, vtx_t'(c));
        send(OpDegree, vtx_t'($urandom_range(0, 63)), u);
        done += n + 1;
      end
    end
  endtask

  initial begin
    int phase_vc     [12] = '{64, 64, 1, 1, 2, 127, 0, 33, 64, 17, 65, 64};
    int phase_dir    [12] = '{0, 1, 0, 1, 0, 1, 0, 0, 0, 1, 1, 1};
    int phase_simple [12] = '{1, 0, 1, 0, 0, 1, 0, 1, 0, 1, 0, 1};
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CfgVertexCount;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    opcode_i        = OpAdd;
    row_vertex_i    = '0;
    column_vertex_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: undirected, simple, all vertices
    send(OpAdd, 10, 11);
    send(OpAdd, 11, 10);
    send(OpQuery, 11, 10);
    // directed removal of a mirrored edge drives the total down to zero and holds it
    configure(64, 1, 1);
    send(OpRemove, 10, 11);
    send(OpRemove, 11, 10);
    send(OpQuery, 10, 11);
    configure(64, 0, 1);
    send(OpAdd, 0, 63);
    send(OpDegree, 63, 63);
    send(OpAdd, 5, 5);
    send(OpAdd, 62, 63);
    send(OpDegree, 0, 63);
    send(OpRemove, 7, 9);
    send(OpAdd, 63, 63);
    // shrunk count, self-loops allowed
    configure(3, 1, 0);
    send(OpAdd, 2, 2);
    send(OpDegree, 0, 2);
    send(OpAdd, 3, 1);
    send(OpDegree, 0, 3);
    send(OpQuery, 0, 63);
    send(OpDegree, 63, 0);
    send(OpRemove, 2, 2);
    // zero count rejects everything
    configure(0, 0, 1);
    send(OpDegree, 0, 0);
    send(OpAdd, 0, 1);

    for (int p = 0; p < 12; p++) begin
      configure(phase_vc[p], phase_dir[p], phase_simple[p]);
      if (p == 3) begin
        // long receiver hold-off while the sender keeps pushing
        quiet_phase  = 1'b1;
        hold_request = 1'b1;
        for (int k = 0; k < 60; k++) begin
          send(op_e'($urandom_range(0, 3)), pick_vertex(graph.active_count()),
               pick_vertex(graph.active_count()));
        end
      end
      quiet_phase = ($urandom_range(0, 3) == 0);
      random_phase((phase_vc[p] == 0) ? 40 : 120);
      if (p == 8) begin
        settle();
        random_phase(40);
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (graph.failures == 0 && graph.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/amgs_pkg.sv
design/amgs_matrix.sv
design/adjacency_matrix_graph_store.sv
tb/sv/adjacency_matrix_graph_store_tb.sv
